@@ sv/csmi_pkg.sv @@
package csmi_pkg;

   // grid and column geometry
   localparam int GRID_X      = 64;
   localparam int GRID_Z      = 64;
   localparam int MAX_SPANS   = 8;
   localparam int HEIGHT_BITS = 13;

   // field widths of the words
   localparam int COORD_W = 6;
   localparam int AREA_W  = 8;
   localparam int COUNT_W = 4;

   // derived sizes
   localparam int NUM_COLS   = GRID_X * GRID_Z;
   localparam int COL_W      = $clog2(NUM_COLS);
   localparam int SPAN_DEPTH = NUM_COLS * MAX_SPANS;
   localparam int SPAN_AW    = $clog2(SPAN_DEPTH);
   localparam int FILL_W     = $clog2(MAX_SPANS + 1);
   localparam int N_W        = $clog2(MAX_SPANS + 2);
   localparam int BUF_DEPTH  = MAX_SPANS + 1;
   localparam int BUF_W      = $clog2(BUF_DEPTH);

   typedef enum logic {
      MODE_ADD  = 1'b0,
      MODE_READ = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_DROP  = 2'd1,
      ST_SPAN  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      mode_type                 mode;
      logic [COORD_W-1:0]       cell_x;
      logic [COORD_W-1:0]       cell_z;
      logic [HEIGHT_BITS-1:0]   new_bottom;
      logic [HEIGHT_BITS-1:0]   new_top;
      logic [AREA_W-1:0]        new_area;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [HEIGHT_BITS-1:0]   span_bottom;
      logic [HEIGHT_BITS-1:0]   span_top;
      logic [AREA_W-1:0]        span_area;
      logic [COUNT_W-1:0]       span_count;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic [HEIGHT_BITS-1:0]   bottom;
      logic [HEIGHT_BITS-1:0]   top;
      logic [AREA_W-1:0]        area;
   } span_type;

   typedef enum logic [1:0] {
      PH_BELOW,
      PH_ABSORB,
      PH_REST
   } phase_type;

   typedef enum logic [1:0] {
      RK_ADD,
      RK_SPAN,
      RK_EMPTY
   } rsp_kind_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_FILL,
      S_ADD_WALK,
      S_ADD_END,
      S_ADD_CHK,
      S_ADD_WB,
      S_RD_ISSUE,
      S_RD_EMIT,
      S_EMIT_ADD,
      S_EMIT_EMPTY
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic         load_item;
      logic         clr_en;
      logic         span_rd;
      logic         walk;
      logic         finish;
      logic         wb;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic     clr_done;
      logic     outside;
      mode_type mode;
      logic     fill_zero;
      logic     rd_more;
      logic     rd_last;
      logic     full;
      logic     wb_last;
      logic     out_free;
   } sts_type;

   // column number of a grid cell
   function automatic logic [COL_W-1:0] col_index(logic [COORD_W-1:0] cx,
                                                  logic [COORD_W-1:0] cz);
      return COL_W'(int'(cz) * GRID_X + int'(cx));
   endfunction

   // span store address of a column slot
   function automatic logic [SPAN_AW-1:0] span_addr(logic [COL_W-1:0] col,
                                                    logic [FILL_W-1:0] idx);
      return SPAN_AW'(int'(col) * MAX_SPANS + int'(idx));
   endfunction

endpackage

@@ sv/csmi_ctrl.sv @@
module csmi_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  csmi_pkg::sts_type  sts,
   output csmi_pkg::cmd_type  cmd
);

   csmi_pkg::state_type state_ff;
   csmi_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csmi_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rsp_kind = csmi_pkg::RK_ADD;
      req_ready    = 1'b0;
      unique case (state_ff)
         csmi_pkg::S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clr_done) begin
               state_in = csmi_pkg::S_IDLE;
            end
         end
         csmi_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = csmi_pkg::S_FILL;
            end
         end
         csmi_pkg::S_FILL: begin
            priority if (sts.outside) begin
               state_in = (sts.mode == csmi_pkg::MODE_READ) ? csmi_pkg::S_EMIT_EMPTY
                                                            : csmi_pkg::S_EMIT_ADD;
            end else if (sts.fill_zero) begin
               state_in = (sts.mode == csmi_pkg::MODE_READ) ? csmi_pkg::S_EMIT_EMPTY
                                                            : csmi_pkg::S_ADD_END;
            end else begin
               cmd.span_rd = 1'b1;
               state_in = (sts.mode == csmi_pkg::MODE_READ) ? csmi_pkg::S_RD_EMIT
                                                            : csmi_pkg::S_ADD_WALK;
            end
         end
         csmi_pkg::S_ADD_WALK: begin
            cmd.walk = 1'b1;
            if (sts.rd_more) begin
               cmd.span_rd = 1'b1;
            end else begin
               state_in = csmi_pkg::S_ADD_END;
            end
         end
         csmi_pkg::S_ADD_END: begin
            cmd.finish = 1'b1;
            state_in   = csmi_pkg::S_ADD_CHK;
         end
         csmi_pkg::S_ADD_CHK: begin
            state_in = sts.full ? csmi_pkg::S_EMIT_ADD : csmi_pkg::S_ADD_WB;
         end
         csmi_pkg::S_ADD_WB: begin
            cmd.wb = 1'b1;
            if (sts.wb_last) begin
               state_in = csmi_pkg::S_EMIT_ADD;
            end
         end
         csmi_pkg::S_RD_ISSUE: begin
            cmd.span_rd = 1'b1;
            state_in    = csmi_pkg::S_RD_EMIT;
         end
         csmi_pkg::S_RD_EMIT: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = csmi_pkg::RK_SPAN;
               state_in = sts.rd_last ? csmi_pkg::S_IDLE : csmi_pkg::S_RD_ISSUE;
            end
         end
         csmi_pkg::S_EMIT_ADD: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = csmi_pkg::RK_ADD;
               state_in     = csmi_pkg::S_IDLE;
            end
         end
         csmi_pkg::S_EMIT_EMPTY: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = csmi_pkg::RK_EMPTY;
               state_in     = csmi_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = csmi_pkg::S_CLEAR;
         end
      endcase
   end

   // an accepted word always goes on to the fill lookup
   a_accept_to_fill: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == csmi_pkg::S_FILL))
      else $error("accepted word did not start fill lookup");

   // no word is taken during the column clear after reset
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_en |-> !cmd.load_item)
      else $error("word accepted during column clear");

endmodule

@@ sv/csmi_dp.sv @@
module csmi_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  csmi_pkg::req_type                   req_word,
   input  csmi_pkg::cmd_type                   cmd,
   output csmi_pkg::sts_type                   sts,
   input  logic                                csr_wr_en,
   input  logic [csmi_pkg::HEIGHT_BITS-1:0]    csr_wr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output csmi_pkg::rsp_type                   rsp_word
);

   // configuration and control registers
   logic [csmi_pkg::HEIGHT_BITS-1:0] thr_ff;
   logic [csmi_pkg::COL_W-1:0]       clr_idx_ff;
   logic [csmi_pkg::FILL_W-1:0]      rd_idx_ff;
   logic                             rsp_valid_ff;
   csmi_pkg::phase_type              phase_ff, phase_in;
   logic [csmi_pkg::N_W-1:0]         n_ff, n_in;
   logic [csmi_pkg::BUF_W-1:0]       wb_idx_ff, wb_idx_in;

   // item registers
   csmi_pkg::mode_type               mode_ff;
   logic                             outside_ff;
   logic [csmi_pkg::COL_W-1:0]       col_ff;
   logic [csmi_pkg::HEIGHT_BITS-1:0] cur_bot_ff, cur_bot_in;
   logic [csmi_pkg::HEIGHT_BITS-1:0] cur_top_ff, cur_top_in;
   logic [csmi_pkg::AREA_W-1:0]      cur_area_ff, cur_area_in;
   csmi_pkg::rsp_type                rsp_ff, rsp_in;

   // merged list buffer
   csmi_pkg::span_type               buf_ff [csmi_pkg::BUF_DEPTH];
   logic                             wr0_en, wr1_en;
   logic [csmi_pkg::BUF_W-1:0]       wr0_idx, wr1_idx;
   csmi_pkg::span_type               wr0_data, wr1_data;

   // memories
   logic [csmi_pkg::FILL_W-1:0]      fill_mem [csmi_pkg::NUM_COLS];
   csmi_pkg::span_type               span_mem [csmi_pkg::SPAN_DEPTH];
   logic [csmi_pkg::FILL_W-1:0]      fill_q_ff;
   csmi_pkg::span_type               span_q_ff;

   // walk helpers
   logic [csmi_pkg::COL_W-1:0]       req_col;
   logic                             req_outside;
   logic                             req_swap;
   csmi_pkg::span_type               cur_span;
   logic                             is_below, touches;
   logic [csmi_pkg::HEIGHT_BITS-1:0] abs_bot, abs_top, abs_diff;
   logic [csmi_pkg::AREA_W-1:0]      abs_area;
   logic                             full, wb_last, out_free;

   assign req_col     = csmi_pkg::col_index(req_word.cell_x, req_word.cell_z);
   assign req_outside = (int'(req_word.cell_x) >= csmi_pkg::GRID_X)
                     || (int'(req_word.cell_z) >= csmi_pkg::GRID_Z);
   assign req_swap    = req_word.new_top < req_word.new_bottom;

   assign cur_span = '{bottom: cur_bot_ff, top: cur_top_ff, area: cur_area_ff};
   assign is_below = span_q_ff.top < cur_bot_ff;
   assign touches  = span_q_ff.bottom <= cur_top_ff;

   // absorb a stored span into the new one
   assign abs_bot  = (span_q_ff.bottom < cur_bot_ff) ? span_q_ff.bottom : cur_bot_ff;
   assign abs_top  = (span_q_ff.top > cur_top_ff) ? span_q_ff.top : cur_top_ff;
   assign abs_diff = abs_top - span_q_ff.top;
   assign abs_area = ((abs_diff <= thr_ff) && (span_q_ff.area > cur_area_ff))
                   ? span_q_ff.area : cur_area_ff;

   assign full     = n_ff > csmi_pkg::N_W'(csmi_pkg::MAX_SPANS);
   assign wb_last  = (csmi_pkg::N_W'(wb_idx_ff) + 1'b1) == n_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // status to the controller
   assign sts.clr_done  = clr_idx_ff == csmi_pkg::COL_W'(csmi_pkg::NUM_COLS - 1);
   assign sts.outside   = outside_ff;
   assign sts.mode      = mode_ff;
   assign sts.fill_zero = fill_q_ff == '0;
   assign sts.rd_more   = rd_idx_ff < fill_q_ff;
   assign sts.rd_last   = rd_idx_ff == fill_q_ff;
   assign sts.full      = full;
   assign sts.wb_last   = wb_last;
   assign sts.out_free  = out_free;

   // walk, merge and list building
   always_comb begin
      cur_bot_in  = cur_bot_ff;
      cur_top_in  = cur_top_ff;
      cur_area_in = cur_area_ff;
      phase_in    = phase_ff;
      n_in        = n_ff;
      wb_idx_in   = wb_idx_ff;
      wr0_en      = 1'b0;
      wr1_en      = 1'b0;
      wr0_idx     = n_ff[csmi_pkg::BUF_W-1:0];
      wr1_idx     = csmi_pkg::BUF_W'(n_ff + 1'b1);
      wr0_data    = span_q_ff;
      wr1_data    = span_q_ff;
      priority if (cmd.load_item) begin
         cur_bot_in  = req_swap ? req_word.new_top : req_word.new_bottom;
         cur_top_in  = req_swap ? req_word.new_bottom : req_word.new_top;
         cur_area_in = req_word.new_area;
         phase_in    = csmi_pkg::PH_BELOW;
         n_in        = '0;
         wb_idx_in   = '0;
      end else if (cmd.walk) begin
         priority if (phase_ff == csmi_pkg::PH_REST) begin
            wr0_en = 1'b1;
            n_in   = n_ff + 1'b1;
         end else if ((phase_ff == csmi_pkg::PH_BELOW) && is_below) begin
            wr0_en = 1'b1;
            n_in   = n_ff + 1'b1;
         end else if (touches) begin
            cur_bot_in  = abs_bot;
            cur_top_in  = abs_top;
            cur_area_in = abs_area;
            phase_in    = csmi_pkg::PH_ABSORB;
         end else begin
            // first span above: place the merged span, then this one
            wr0_en    = 1'b1;
            wr0_data  = cur_span;
            wr1_en    = 1'b1;
            wb_idx_in = n_ff[csmi_pkg::BUF_W-1:0];
            n_in      = csmi_pkg::N_W'(n_ff + 2'd2);
            phase_in  = csmi_pkg::PH_REST;
         end
      end else if (cmd.finish) begin
         if (phase_ff != csmi_pkg::PH_REST) begin
            wr0_en    = 1'b1;
            wr0_data  = cur_span;
            wb_idx_in = n_ff[csmi_pkg::BUF_W-1:0];
            n_in      = n_ff + 1'b1;
            phase_in  = csmi_pkg::PH_REST;
         end
      end else if (cmd.wb) begin
         wb_idx_in = wb_idx_ff + 1'b1;
      end else begin
         // no command: everything holds
      end
   end

   // result word
   always_comb begin
      rsp_in = '0;
      unique case (cmd.rsp_kind)
         csmi_pkg::RK_ADD: begin
            priority if (outside_ff) begin
               rsp_in.status     = csmi_pkg::ST_DROP;
               rsp_in.span_count = '0;
            end else if (full) begin
               rsp_in.status     = csmi_pkg::ST_DROP;
               rsp_in.span_count = csmi_pkg::COUNT_W'(fill_q_ff);
            end else begin
               rsp_in.status     = csmi_pkg::ST_DONE;
               rsp_in.span_count = csmi_pkg::COUNT_W'(n_ff);
            end
            rsp_in.last = 1'b1;
         end
         csmi_pkg::RK_SPAN: begin
            rsp_in.status      = csmi_pkg::ST_SPAN;
            rsp_in.span_bottom = span_q_ff.bottom;
            rsp_in.span_top    = span_q_ff.top;
            rsp_in.span_area   = span_q_ff.area;
            rsp_in.span_count  = csmi_pkg::COUNT_W'(fill_q_ff);
            rsp_in.last        = rd_idx_ff == fill_q_ff;
         end
         csmi_pkg::RK_EMPTY: begin
            rsp_in.status = csmi_pkg::ST_EMPTY;
            rsp_in.last   = 1'b1;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= csmi_pkg::HEIGHT_BITS'(1);
         clr_idx_ff   <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= csmi_pkg::PH_BELOW;
         n_ff         <= '0;
         wb_idx_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (cmd.clr_en) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         if (cmd.load_item) begin
            rd_idx_ff <= '0;
         end else if (cmd.span_rd) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         phase_ff  <= phase_in;
         n_ff      <= n_in;
         wb_idx_ff <= wb_idx_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff    <= req_word.mode;
         outside_ff <= req_outside;
         col_ff     <= req_col;
      end
      cur_bot_ff  <= cur_bot_in;
      cur_top_ff  <= cur_top_in;
      cur_area_ff <= cur_area_in;
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // merged list buffer
   always_ff @(posedge clock) begin
      if (wr0_en) begin
         buf_ff[wr0_idx] <= wr0_data;
      end
      if (wr1_en) begin
         buf_ff[wr1_idx] <= wr1_data;
      end
   end

   // column fill memory
   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         fill_mem[clr_idx_ff] <= '0;
      end else if (cmd.wb && wb_last) begin
         fill_mem[col_ff] <= csmi_pkg::FILL_W'(n_ff);
      end
      if (cmd.load_item) begin
         fill_q_ff <= fill_mem[req_col];
      end
   end

   // span memory
   always_ff @(posedge clock) begin
      if (cmd.wb) begin
         span_mem[csmi_pkg::span_addr(col_ff, wb_idx_ff)] <= buf_ff[wb_idx_ff];
      end
      if (cmd.span_rd) begin
         span_q_ff <= span_mem[csmi_pkg::span_addr(col_ff, rd_idx_ff)];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // a result is only loaded into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> out_free)
      else $error("result loaded over a pending word");

   // write-back stays inside the merged list and never on an overflowing one
   a_wb_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.wb |-> ((csmi_pkg::N_W'(wb_idx_ff) < n_ff) && !full))
      else $error("write-back outside merged list");

   // span reads stay below the column fill
   a_rd_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.span_rd |-> (rd_idx_ff < fill_q_ff))
      else $error("span read beyond column fill");

   // merged list never grows past one over capacity
   a_n_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= csmi_pkg::N_W'(csmi_pkg::MAX_SPANS + 1))
      else $error("merged list overflow");

endmodule

@@ sv/column_span_merge_insert.sv @@
// an add word reads the column fill, walks its stored spans and writes back the list;
// a dropped add skips the write-back; a read word sends one result per stored span
// one word at a time; no new word is taken during the span memory walk of the column
// results leave through an output register, so a new word is taken while one waits
// synchronous reset clears control and sets merge_threshold to 1, then a clearing
// pass zeroes the column fill memory, one column a cycle (every column, no words taken)
module column_span_merge_insert (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  csmi_pkg::req_type                 req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output csmi_pkg::rsp_type                 rsp_word,
   input  logic                              csr_wr_en,
   input  logic [csmi_pkg::HEIGHT_BITS-1:0]  csr_wr_data
);

   csmi_pkg::cmd_type cmd;
   csmi_pkg::sts_type sts;

   // sequencer
   csmi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // memories, merge logic and output register
   csmi_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_word),
      .cmd         (cmd),
      .sts         (sts),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

endmodule

@@ tb/sv/tb_column_span_merge_insert.sv @@
module tb_column_span_merge_insert;
   import csmi_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int LONG_HOLD      = 400;
   localparam int HOT_COLUMNS    = 6;
   localparam int REPORT_LIMIT   = 10;

   // tracks every column's span list and the words the block owes us
   class column_span_tracker;
      span_type               column_spans[NUM_COLS][MAX_SPANS];
      int unsigned            column_count[NUM_COLS];
      logic [HEIGHT_BITS-1:0] threshold;
      rsp_type                awaited_words[$];
      int                     mismatches;

      function new();
         threshold  = 1;
         mismatches = 0;
         foreach (column_count[i]) column_count[i] = 0;
      endfunction

      function void await_word(status_type st, span_type s, int unsigned cnt, logic fin);
         rsp_type w;
         w.status      = st;
         w.span_bottom = s.bottom;
         w.span_top    = s.top;
         w.span_area   = s.area;
         w.span_count  = COUNT_W'(cnt);
         w.last        = fin;
         awaited_words.push_back(w);
      endfunction

      // work out the words that one accepted request causes
      function void record_request(req_type w);
         span_type    merged[MAX_SPANS+1];
         span_type    blank;
         span_type    cur;
         int unsigned col, fill, n, idx, lo, hi, ar, ct;
         blank = '0;
         if (int'(w.cell_x) >= GRID_X || int'(w.cell_z) >= GRID_Z) begin
            await_word(w.mode == MODE_READ ? ST_EMPTY : ST_DROP, blank, 0, 1'b1);
            return;
         end
         col  = int'(w.cell_x) + int'(w.cell_z) * GRID_X;
         fill = column_count[col];
         // read out, lowest span first
         if (w.mode == MODE_READ) begin
            if (fill == 0) await_word(ST_EMPTY, blank, 0, 1'b1);
            for (idx = 0; idx < fill; idx++)
               await_word(ST_SPAN, column_spans[col][idx], fill, idx + 1 == fill);
            return;
         end
         lo = w.new_bottom;
         hi = w.new_top;
         ar = w.new_area;
         if (hi < lo) begin
            lo = w.new_top;
            hi = w.new_bottom;
         end
         n   = 0;
         idx = 0;
         // spans wholly below stay as they are
         while (idx < fill && column_spans[col][idx].top < lo) begin
            merged[n] = column_spans[col][idx];
            n++;
            idx++;
         end
         // overlapping or touching spans are swallowed
         while (idx < fill && column_spans[col][idx].bottom <= hi) begin
            cur = column_spans[col][idx];
            ct  = cur.top;
            if (cur.bottom < lo) lo = cur.bottom;
            if (ct > hi) hi = ct;
            if (hi - ct <= threshold && cur.area > ar) ar = cur.area;
            idx++;
         end
         merged[n].bottom = HEIGHT_BITS'(lo);
         merged[n].top    = HEIGHT_BITS'(hi);
         merged[n].area   = AREA_W'(ar);
         n++;
         while (idx < fill) begin
            merged[n] = column_spans[col][idx];
            n++;
            idx++;
         end
         // column over capacity: nothing changes
         if (n > MAX_SPANS) begin
            await_word(ST_DROP, blank, fill, 1'b1);
            return;
         end
         for (idx = 0; idx < n; idx++) column_spans[col][idx] = merged[idx];
         column_count[col] = n;
         await_word(ST_DONE, blank, n, 1'b1);
      endfunction

      // compare a delivered word with the oldest one owed
      function void check_span_word(rsp_type got);
         rsp_type want;
         if (awaited_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("mismatch: unexpected st=%0d bot=%0d top=%0d area=%0d cnt=%0d last=%0b",
                        got.status, got.span_bottom, got.span_top, got.span_area,
                        got.span_count, got.last);
            return;
         end
         want = awaited_words.pop_front();
         if (got.status !== want.status || got.span_bottom !== want.span_bottom ||
             got.span_top !== want.span_top || got.span_area !== want.span_area ||
             got.span_count !== want.span_count || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("mismatch: got  st=%0d bot=%0d top=%0d area=%0d cnt=%0d last=%0b",
                        got.status, got.span_bottom, got.span_top, got.span_area,
                        got.span_count, got.last);
               $display("          want st=%0d bot=%0d top=%0d area=%0d cnt=%0d last=%0b",
                        want.status, want.span_bottom, want.span_top, want.span_area,
                        want.span_count, want.last);
            end
         end
      endfunction
   endclass

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_type                req_word    = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_type                rsp_word;
   logic                   csr_wr_en   = 1'b0;
   logic [HEIGHT_BITS-1:0] csr_wr_data = '0;

   column_span_tracker     tracker = new();
   bit                     long_hold_pending = 1'b0;
   logic [COORD_W-1:0]     hot_x[HOT_COLUMNS];
   logic [COORD_W-1:0]     hot_z[HOT_COLUMNS];

   column_span_merge_insert u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_span_word(rsp_word);
   end

   // receiver stall pattern, with one long hold-off on request
   initial begin : receiver
      int style;
      int run_len;
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            style   = $urandom_range(0, 3);
            run_len = $urandom_range(5, 60);
            repeat (run_len) begin
               case (style)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= 1'($urandom_range(0, 1));
                  2: rsp_ready <= ($urandom_range(0, 3) != 0);
                  default: rsp_ready <= ($urandom_range(0, 4) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   // offer one word and hold it until taken
   task automatic push_request(input req_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      tracker.record_request(w);
   endtask

   task automatic send_directed(input mode_type m, input int x, input int z,
                                input int bot, input int top, input int area);
      req_type w;
      w.mode       = m;
      w.cell_x     = COORD_W'(x);
      w.cell_z     = COORD_W'(z);
      w.new_bottom = HEIGHT_BITS'(bot);
      w.new_top    = HEIGHT_BITS'(top);
      w.new_area   = AREA_W'(area);
      push_request(w);
   endtask

   // mostly short spans low in a handful of busy columns, some noise
   function automatic req_type random_request();
      req_type w;
      int      pick;
      int      base;
      w.mode = ($urandom_range(0, 99) < 25) ? MODE_READ : MODE_ADD;
      if ($urandom_range(0, 9) < 8) begin
         pick     = $urandom_range(0, HOT_COLUMNS - 1);
         w.cell_x = hot_x[pick];
         w.cell_z = hot_z[pick];
      end else begin
         w.cell_x = COORD_W'($urandom_range(0, 63));
         w.cell_z = COORD_W'($urandom_range(0, 63));
      end
      case ($urandom_range(0, 9))
         0, 1: begin
            w.new_bottom = HEIGHT_BITS'($urandom_range(0, 8191));
            w.new_top    = HEIGHT_BITS'($urandom_range(0, 8191));
         end
         2: begin
            base         = 8191 - $urandom_range(0, 40);
            w.new_top    = HEIGHT_BITS'(base);
            w.new_bottom = HEIGHT_BITS'(base - $urandom_range(0, 15));
         end
         default: begin
            base         = $urandom_range(0, 300);
            w.new_bottom = HEIGHT_BITS'(base);
            w.new_top    = HEIGHT_BITS'(base + $urandom_range(0, 15));
            if ($urandom_range(0, 9) == 0) begin
               w.new_bottom = HEIGHT_BITS'(base + $urandom_range(0, 15));
               w.new_top    = HEIGHT_BITS'(base);
            end
         end
      endcase
      w.new_area = AREA_W'($urandom_range(0, 255));
      return w;
   endfunction

   task automatic pick_hot_columns();
      hot_x[0] = '0;
      hot_z[0] = '0;
      for (int k = 1; k < HOT_COLUMNS; k++) begin
         hot_x[k] = COORD_W'($urandom_range(0, 63));
         hot_z[k] = COORD_W'($urandom_range(0, 63));
      end
   endtask

   // sender bursts with random gaps in between
   task automatic send_random(input int count);
      int burst_left;
      int gap;
      burst_left = $urandom_range(1, 24);
      for (int k = 0; k < count; k++) begin
         push_request(random_request());
         burst_left--;
         if (burst_left == 0 && k != count - 1) begin
            gap = $urandom_range(1, 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
      end
      req_valid <= 1'b0;
   endtask

   // let every owed word arrive, then change the threshold
   task automatic drain_and_set(input logic [HEIGHT_BITS-1:0] value);
      while (tracker.awaited_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      tracker.threshold = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty read, extremes, swapped heights, touching and close tops
      send_directed(MODE_READ, 0, 0, 0, 0, 0);
      send_directed(MODE_ADD, 63, 63, 8191, 8191, 255);
      send_directed(MODE_READ, 63, 63, 0, 0, 0);
      send_directed(MODE_ADD, 0, 0, 100, 50, 3);
      send_directed(MODE_ADD, 0, 0, 100, 120, 7);
      send_directed(MODE_ADD, 0, 0, 60, 121, 2);
      send_directed(MODE_ADD, 0, 0, 0, 0, 0);
      send_directed(MODE_ADD, 0, 0, 2, 3, 9);
      send_directed(MODE_READ, 0, 0, 0, 0, 0);
      // fill a column, overflow it, then merge within it
      for (int k = 0; k < MAX_SPANS; k++)
         send_directed(MODE_ADD, 1, 0, 10 * k, 10 * k + 2, k + 1);
      send_directed(MODE_ADD, 1, 0, 200, 201, 4);
      send_directed(MODE_READ, 1, 0, 0, 0, 0);
      send_directed(MODE_ADD, 1, 0, 0, 25, 50);
      send_directed(MODE_ADD, 1, 0, 8191, 0, 1);
      send_directed(MODE_READ, 1, 0, 0, 0, 0);
      send_directed(MODE_ADD, 0, 63, 0, 8191, 128);
      send_directed(MODE_READ, 0, 63, 0, 0, 0);
      req_valid <= 1'b0;

      drain_and_set('0);
      pick_hot_columns();
      send_random(70);

      // long receiver hold-off while the sender keeps offering
      drain_and_set('1);
      pick_hot_columns();
      long_hold_pending = 1'b1;
      send_random(70);

      drain_and_set(HEIGHT_BITS'($urandom_range(0, 8191)));
      pick_hot_columns();
      send_random(65);

      drain_and_set(HEIGHT_BITS'($urandom_range(0, 64)));
      send_random(65);

      while (tracker.awaited_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.awaited_words.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
